[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the LED animation controller.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/ralc_pkg.sv]
// Package of the RGB LED animation controller: codes, types and shared functions.
// Depends on nothing; the modules of the block and the bench refer to it by scoped names.
package ralc_pkg;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_PERIOD    = 2'd0;
  localparam logic [1:0] REG_SWEEP_MIN = 2'd1;
  localparam logic [1:0] REG_SWEEP_MAX = 2'd2;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_EVT_A = 2'd2;
  localparam logic [1:0] ACT_EVT_B = 2'd3;

  localparam logic [2:0] MODE_OFF           = 3'd0;
  localparam logic [2:0] MODE_SOLID         = 3'd1;
  localparam logic [2:0] MODE_FADE          = 3'd2;
  localparam logic [2:0] MODE_FADE_BLINK3   = 3'd3;
  localparam logic [2:0] MODE_BLINK         = 3'd4;
  localparam logic [2:0] MODE_BLINK_FOREVER = 3'd5;
  localparam logic [2:0] MODE_DISCO         = 3'd6;
  localparam logic [2:0] MODE_NONE          = 3'd7;

  localparam logic [7:0]  FULL_SCALE    = 8'hFF;
  localparam logic [6:0]  FADE_DIVIDE   = 7'h7F;
  localparam logic [7:0]  SWEEP_DIVIDE  = 8'hFF;
  localparam logic [15:0] FADE_BLINKS   = 16'd3;
  localparam logic [15:0] PERIOD_RESET  = 16'd255;
  localparam logic [15:0] SWEEP_MIN_RST = 16'd0;
  localparam logic [15:0] SWEEP_MAX_RST = 16'd255;

  typedef struct packed {
    logic [15:0] pwm_period;
    logic [15:0] sweep_min;
    logic [15:0] sweep_max;
  } ralc_cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] duration;
  } ralc_cmd_t;

  typedef struct packed {
    logic [15:0] red_duty;
    logic [15:0] green_duty;
    logic [15:0] blue_duty;
    logic [2:0]  current_mode;
    logic        unit_a_events_on;
    logic        unit_b_events_on;
  } ralc_result_t;

  typedef struct packed {
    logic        up;
    logic [15:0] val;
  } ralc_sweep_t;

  // Computes colour * alpha / 255 exactly for 16-bit products, then lowers a
  // duty that equals the period by one.
  function automatic logic [15:0] scale_duty(input logic [7:0] c, input logic [7:0] a,
                                             input logic [15:0] period);
    logic [15:0] prod;
    logic [16:0] sum;
    logic [15:0] s;
    prod = {8'd0, c} * {8'd0, a};
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    s    = {8'd0, sum[15:8]};
    if (s == period) begin
      s = period - 16'd1;
    end
    return s;
  endfunction

  // One step of the triangle sweep between lo and hi.
  function automatic ralc_sweep_t sweep_step(input logic [15:0] v, input logic up,
                                             input logic [15:0] lo, input logic [15:0] hi);
    ralc_sweep_t r;
    r.up = up;
    if (up) begin
      if (v < hi) begin
        r.val = v + 16'd1;
      end else begin
        r.up  = 1'b0;
        r.val = v - 16'd1;
      end
    end else if (v == lo) begin
      r.up  = 1'b1;
      r.val = v + 16'd1;
    end else begin
      r.val = v - 16'd1;
    end
    return r;
  endfunction

endpackage

[rtl/ralc_cmd_if.sv]
// Command channel of the LED animation controller: one command word per handshake.
// Depends on nothing.
interface ralc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  mode;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] duration;

  modport source (output valid, action, mode, red, green, blue, alpha, duration,
                  input ready);
  modport sink (input valid, action, mode, red, green, blue, alpha, duration,
                output ready);
endinterface

[rtl/ralc_duty_if.sv]
// Result channel of the LED animation controller: one duty word per handshake.
// Depends on nothing.
interface ralc_duty_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_duty;
  logic [15:0] green_duty;
  logic [15:0] blue_duty;
  logic [2:0]  current_mode;
  logic        unit_a_events_on;
  logic        unit_b_events_on;

  modport source (output valid, red_duty, green_duty, blue_duty, current_mode,
                  unit_a_events_on, unit_b_events_on, input ready);
  modport sink (input valid, red_duty, green_duty, blue_duty, current_mode,
                unit_a_events_on, unit_b_events_on, output ready);
endinterface

[rtl/ralc_cfg_regs.sv]
// APB register file of the LED animation controller: period and sweep limits.
// Depends on ralc_pkg.
module ralc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ralc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ralc_pkg::ralc_cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ralc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_period <= ralc_pkg::PERIOD_RESET;
      cfg.sweep_min  <= ralc_pkg::SWEEP_MIN_RST;
      cfg.sweep_max  <= ralc_pkg::SWEEP_MAX_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ralc_pkg::REG_PERIOD:    cfg.pwm_period <= pwdata[15:0];
        ralc_pkg::REG_SWEEP_MIN: cfg.sweep_min  <= pwdata[15:0];
        ralc_pkg::REG_SWEEP_MAX: cfg.sweep_max  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ralc_pkg::REG_PERIOD:    prdata = {16'd0, cfg.pwm_period};
      ralc_pkg::REG_SWEEP_MIN: prdata = {16'd0, cfg.sweep_min};
      ralc_pkg::REG_SWEEP_MAX: prdata = {16'd0, cfg.sweep_max};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

[rtl/ralc_in_reg.sv]
// Input register of the LED animation controller: captures one command word.
// Depends on ralc_pkg and ralc_cmd_if.
module ralc_in_reg (
  input  logic                clk,
  input  logic                rst,
  ralc_cmd_if.sink            cmd,
  input  logic                take,
  output logic                item_valid,
  output ralc_pkg::ralc_cmd_t item
);

  assign cmd.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.action   <= cmd.action;
      item.mode     <= cmd.mode;
      item.red      <= cmd.red;
      item.green    <= cmd.green;
      item.blue     <= cmd.blue;
      item.alpha    <= cmd.alpha;
      item.duration <= cmd.duration;
    end
  end

endmodule

[rtl/ralc_anim.sv]
// Animation state and result register of the LED animation controller.
// Depends on ralc_pkg and ralc_duty_if.
module ralc_anim (
  input  logic                clk,
  input  logic                rst,
  input  ralc_pkg::ralc_cfg_t cfg,
  input  logic                item_valid,
  input  ralc_pkg::ralc_cmd_t item,
  output logic                take,
  ralc_duty_if.source         duty
);

  logic [2:0]  mode_reg;
  logic [7:0]  stored_red;
  logic [7:0]  stored_green;
  logic [7:0]  stored_blue;
  logic [8:0]  stored_alpha;
  logic [15:0] blinks_left;
  logic        blink_phase;
  logic [6:0]  fade_prescale;
  logic        use_fade_update;
  logic [1:0]  events_enabled;
  logic [15:0] duty_regs [3];
  logic [2:0]  sweep_up;
  logic [7:0]  sweep_prescale [2];

  logic [2:0]  mode_reg_next;
  logic [7:0]  stored_red_next;
  logic [7:0]  stored_green_next;
  logic [7:0]  stored_blue_next;
  logic [8:0]  stored_alpha_next;
  logic [15:0] blinks_left_next;
  logic        blink_phase_next;
  logic [6:0]  fade_prescale_next;
  logic        use_fade_update_next;
  logic [1:0]  events_enabled_next;
  logic [15:0] duty_regs_next [3];
  logic [2:0]  sweep_up_next;
  logic [7:0]  sweep_prescale_next [2];

  logic                   res_valid;
  ralc_pkg::ralc_result_t res;

  logic                   apply;
  logic [7:0]             col_r;
  logic [7:0]             col_g;
  logic [7:0]             col_b;
  logic [7:0]             alpha_sel;
  logic                   unit;
  logic                   sweep_a;
  logic                   sweep_b;
  ralc_pkg::ralc_sweep_t  sw [3];

  assign take = item_valid && (!res_valid || duty.ready);

  assign sw[0] = ralc_pkg::sweep_step(duty_regs[0], sweep_up[0], cfg.sweep_min, cfg.sweep_max);
  assign sw[1] = ralc_pkg::sweep_step(duty_regs[1], sweep_up[1], cfg.sweep_min, cfg.sweep_max);
  assign sw[2] = ralc_pkg::sweep_step(duty_regs[2], sweep_up[2], cfg.sweep_min, cfg.sweep_max);

  always_comb begin
    mode_reg_next          = mode_reg;
    stored_red_next        = stored_red;
    stored_green_next      = stored_green;
    stored_blue_next       = stored_blue;
    stored_alpha_next      = stored_alpha;
    blinks_left_next       = blinks_left;
    blink_phase_next       = blink_phase;
    fade_prescale_next     = fade_prescale;
    use_fade_update_next   = use_fade_update;
    events_enabled_next    = events_enabled;
    sweep_up_next          = sweep_up;
    sweep_prescale_next[0] = sweep_prescale[0];
    sweep_prescale_next[1] = sweep_prescale[1];
    apply                  = 1'b0;
    col_r                  = stored_red;
    col_g                  = stored_green;
    col_b                  = stored_blue;
    alpha_sel              = stored_alpha[7:0];
    sweep_a                = 1'b0;
    sweep_b                = 1'b0;
    unit                   = (item.action == ralc_pkg::ACT_EVT_B);

    case (item.action)
      ralc_pkg::ACT_SET: begin
        mode_reg_next = item.mode;
        case (item.mode)
          ralc_pkg::MODE_OFF: begin
            events_enabled_next = 2'b00;
            apply               = 1'b1;
            alpha_sel           = 8'd0;
          end
          ralc_pkg::MODE_SOLID: begin
            events_enabled_next = 2'b00;
            apply               = 1'b1;
            col_r               = item.red;
            col_g               = item.green;
            col_b               = item.blue;
            alpha_sel           = item.alpha;
          end
          ralc_pkg::MODE_FADE, ralc_pkg::MODE_FADE_BLINK3: begin
            stored_red_next      = item.red;
            stored_green_next    = item.green;
            stored_blue_next     = item.blue;
            stored_alpha_next    = 9'd1;
            use_fade_update_next = 1'b1;
            events_enabled_next  = 2'b01;
          end
          ralc_pkg::MODE_BLINK, ralc_pkg::MODE_BLINK_FOREVER: begin
            events_enabled_next = 2'b00;
            stored_red_next     = item.red;
            stored_green_next   = item.green;
            stored_blue_next    = item.blue;
            stored_alpha_next   = {1'b0, item.alpha};
            blinks_left_next    = item.duration;
          end
          ralc_pkg::MODE_DISCO: begin
            use_fade_update_next = 1'b0;
            events_enabled_next  = 2'b11;
          end
          default: begin
          end
        endcase
      end
      ralc_pkg::ACT_TICK: begin
        if (mode_reg == ralc_pkg::MODE_BLINK || mode_reg == ralc_pkg::MODE_BLINK_FOREVER) begin
          apply = 1'b1;
          if (!blink_phase) begin
            blink_phase_next = 1'b1;
            blinks_left_next = blinks_left - 16'd1;
          end else begin
            alpha_sel        = 8'd0;
            blink_phase_next = 1'b0;
            if (blinks_left == 16'd0 && mode_reg == ralc_pkg::MODE_BLINK) begin
              mode_reg_next = ralc_pkg::MODE_OFF;
            end
          end
        end
      end
      ralc_pkg::ACT_EVT_A, ralc_pkg::ACT_EVT_B: begin
        if (events_enabled[unit]) begin
          if (use_fade_update) begin
            if (fade_prescale != ralc_pkg::FADE_DIVIDE) begin
              fade_prescale_next = fade_prescale + 7'd1;
            end else begin
              fade_prescale_next = 7'd0;
              if (!stored_alpha[8]) begin
                apply             = 1'b1;
                stored_alpha_next = stored_alpha + 9'd1;
              end else if (mode_reg == ralc_pkg::MODE_FADE_BLINK3) begin
                blink_phase_next    = 1'b1;
                mode_reg_next       = ralc_pkg::MODE_BLINK;
                events_enabled_next = 2'b00;
                stored_alpha_next   = {1'b0, ralc_pkg::FULL_SCALE};
                blinks_left_next    = ralc_pkg::FADE_BLINKS;
              end else begin
                mode_reg_next       = ralc_pkg::MODE_SOLID;
                events_enabled_next = 2'b00;
              end
            end
          end else if (sweep_prescale[unit] == ralc_pkg::SWEEP_DIVIDE) begin
            sweep_prescale_next[unit] = 8'd0;
            sweep_a                   = !unit;
            sweep_b                   = unit;
          end else begin
            sweep_prescale_next[unit] = sweep_prescale[unit] + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase

    if (sweep_a) begin
      sweep_up_next[0] = sw[0].up;
      sweep_up_next[1] = sw[1].up;
    end
    if (sweep_b) begin
      sweep_up_next[2] = sw[2].up;
    end

    if (apply) begin
      duty_regs_next[0] = ralc_pkg::scale_duty(col_r, alpha_sel, cfg.pwm_period);
      duty_regs_next[1] = ralc_pkg::scale_duty(col_g, alpha_sel, cfg.pwm_period);
      duty_regs_next[2] = ralc_pkg::scale_duty(col_b, alpha_sel, cfg.pwm_period);
    end else begin
      duty_regs_next[0] = sweep_a ? sw[0].val : duty_regs[0];
      duty_regs_next[1] = sweep_a ? sw[1].val : duty_regs[1];
      duty_regs_next[2] = sweep_b ? sw[2].val : duty_regs[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= ralc_pkg::MODE_OFF;
      stored_red        <= 8'd0;
      stored_green      <= 8'd0;
      stored_blue       <= 8'd0;
      stored_alpha      <= 9'd0;
      blinks_left       <= 16'd0;
      blink_phase       <= 1'b0;
      fade_prescale     <= 7'd0;
      use_fade_update   <= 1'b0;
      events_enabled    <= 2'b00;
      duty_regs[0]      <= ralc_pkg::SWEEP_MIN_RST;
      duty_regs[1]      <= ralc_pkg::SWEEP_MIN_RST;
      duty_regs[2]      <= ralc_pkg::SWEEP_MIN_RST;
      sweep_up          <= 3'b111;
      sweep_prescale[0] <= 8'd0;
      sweep_prescale[1] <= 8'd0;
      res_valid         <= 1'b0;
    end else begin
      if (take) begin
        mode_reg          <= mode_reg_next;
        stored_red        <= stored_red_next;
        stored_green      <= stored_green_next;
        stored_blue       <= stored_blue_next;
        stored_alpha      <= stored_alpha_next;
        blinks_left       <= blinks_left_next;
        blink_phase       <= blink_phase_next;
        fade_prescale     <= fade_prescale_next;
        use_fade_update   <= use_fade_update_next;
        events_enabled    <= events_enabled_next;
        duty_regs[0]      <= duty_regs_next[0];
        duty_regs[1]      <= duty_regs_next[1];
        duty_regs[2]      <= duty_regs_next[2];
        sweep_up          <= sweep_up_next;
        sweep_prescale[0] <= sweep_prescale_next[0];
        sweep_prescale[1] <= sweep_prescale_next[1];
        res_valid         <= 1'b1;
      end else if (duty.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.red_duty         <= duty_regs_next[0];
      res.green_duty       <= duty_regs_next[1];
      res.blue_duty        <= duty_regs_next[2];
      res.current_mode     <= mode_reg_next;
      res.unit_a_events_on <= events_enabled_next[0];
      res.unit_b_events_on <= events_enabled_next[1];
    end
  end

  assign duty.valid            = res_valid;
  assign duty.red_duty         = res.red_duty;
  assign duty.green_duty       = res.green_duty;
  assign duty.blue_duty        = res.blue_duty;
  assign duty.current_mode     = res.current_mode;
  assign duty.unit_a_events_on = res.unit_a_events_on;
  assign duty.unit_b_events_on = res.unit_b_events_on;

endmodule

[rtl/rgb_led_animation_controller_core.sv]
// A command word is captured in the input register, and its duty word is then registered
// in the result register. One word per cycle while the sink is ready; the animation
// state is updated in the cycle that moves a word from the input to the result register.
// Reset (rst, synchronous): mode off, duties zero, events off, registers to defaults.
// Depends on ralc_pkg, ralc_cmd_if, ralc_duty_if, ralc_cfg_regs, ralc_in_reg, ralc_anim.
module rgb_led_animation_controller_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ralc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  ralc_cmd_if.sink                    cmd,
  ralc_duty_if.source                 duty
);

  ralc_pkg::ralc_cfg_t cfg;
  ralc_pkg::ralc_cmd_t item;
  logic                item_valid;
  logic                take;

  ralc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ralc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ralc_anim u_anim (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .duty       (duty)
  );

endmodule

[rtl/ralc_checker.sv]
// Port-level checks of the LED animation controller and their bind to the top level.
// Depends on ralc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ralc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] red_duty,
  input logic [2:0]  current_mode,
  input logic        ev_a,
  input logic        ev_b
);

  logic        quiet_mode;
  logic        fade_mode;
  logic        disco_mode;
  logic [18:0] held_word;

  assign quiet_mode = current_mode == ralc_pkg::MODE_OFF ||
                      current_mode == ralc_pkg::MODE_SOLID ||
                      current_mode == ralc_pkg::MODE_BLINK ||
                      current_mode == ralc_pkg::MODE_BLINK_FOREVER;
  assign fade_mode  = current_mode == ralc_pkg::MODE_FADE ||
                      current_mode == ralc_pkg::MODE_FADE_BLINK3;
  assign disco_mode = current_mode == ralc_pkg::MODE_DISCO;
  assign held_word  = {red_duty, current_mode};

  `ASSERT_NEXT(a_rst_clears_valid, clk, 1'b0, rst, !out_valid)
  `ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(held_word))
  `ASSERT_SAME(a_quiet_no_events, clk, rst, out_valid && quiet_mode, !ev_a && !ev_b)
  `ASSERT_SAME(a_fade_unit_a_only, clk, rst, out_valid && fade_mode, ev_a && !ev_b)
  `ASSERT_SAME(a_disco_both_units, clk, rst, out_valid && disco_mode, ev_a && ev_b)

endmodule

bind rgb_led_animation_controller_core ralc_checker u_ralc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (duty.valid),
  .out_ready    (duty.ready),
  .red_duty     (duty.red_duty),
  .current_mode (duty.current_mode),
  .ev_a         (duty.unit_a_events_on),
  .ev_b         (duty.unit_b_events_on)
);

[test/tb_rgb_led_animation_controller_core.sv]
`timescale 1ns / 100ps
// Testbench of rgb_led_animation_controller_core: directed, random and long-run command
// words whose duty words are checked against an in-bench model of the LED animation.
// Depends on ralc_pkg, ralc_cmd_if, ralc_duty_if and the block itself.
module tb_rgb_led_animation_controller_core;

  localparam int STALL_LIMIT = 5000;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ralc_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  ralc_cmd_if  cmd_ch ();
  ralc_duty_if duty_ch ();

  rgb_led_animation_controller_core DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd_ch), .duty(duty_ch)
  );

  logic [15:0] period_cfg;
  logic [15:0] sweep_lo;
  logic [15:0] sweep_hi;
  logic [2:0]  anim_mode;
  logic [7:0]  keep_red;
  logic [7:0]  keep_green;
  logic [7:0]  keep_blue;
  logic [8:0]  keep_alpha;
  logic [15:0] blinks_left;
  logic        lit_phase;
  logic [6:0]  fade_div;
  logic        fading;
  logic [1:0]  unit_on;
  logic [15:0] duty_val [3];
  logic        rising [3];
  logic [7:0]  sweep_div [2];

  ralc_pkg::ralc_result_t duty_queue [$];
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int fades_done = 0;
  int blinks_done = 0;
  int src_idle;
  int snk_idle;
  int hold_left;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic model_reset();
    period_cfg  = ralc_pkg::PERIOD_RESET;
    sweep_lo    = ralc_pkg::SWEEP_MIN_RST;
    sweep_hi    = ralc_pkg::SWEEP_MAX_RST;
    anim_mode   = ralc_pkg::MODE_OFF;
    keep_red    = 8'd0;
    keep_green  = 8'd0;
    keep_blue   = 8'd0;
    keep_alpha  = 9'd0;
    blinks_left = 16'd0;
    lit_phase   = 1'b0;
    fade_div    = 7'd0;
    fading      = 1'b0;
    unit_on     = 2'b00;
    for (int i = 0; i < 3; i++) begin
      duty_val[i] = ralc_pkg::SWEEP_MIN_RST;
      rising[i]   = 1'b1;
    end
    sweep_div[0] = 8'd0;
    sweep_div[1] = 8'd0;
  endtask

  function automatic logic [15:0] scaled_duty(input logic [7:0] c, input logic [7:0] a);
    int unsigned s;
    int unsigned cc;
    int unsigned aa;
    cc = {24'd0, c};
    aa = {24'd0, a};
    s = (cc * aa) / 255;
    if (s == period_cfg) begin
      return period_cfg - 16'd1;
    end
    return s[15:0];
  endfunction

  function automatic void paint(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] a);
    duty_val[0] = scaled_duty(r, a);
    duty_val[1] = scaled_duty(g, a);
    duty_val[2] = scaled_duty(b, a);
  endfunction

  function automatic void sweep_duty(input int d);
    if (rising[d]) begin
      if (duty_val[d] < sweep_hi) begin
        duty_val[d] = duty_val[d] + 16'd1;
      end else begin
        rising[d]   = 1'b0;
        duty_val[d] = duty_val[d] - 16'd1;
      end
    end else if (duty_val[d] == sweep_lo) begin
      rising[d]   = 1'b1;
      duty_val[d] = duty_val[d] + 16'd1;
    end else begin
      duty_val[d] = duty_val[d] - 16'd1;
    end
  endfunction

  function automatic void fade_event();
    if (fade_div != ralc_pkg::FADE_DIVIDE) begin
      fade_div = fade_div + 7'd1;
    end else begin
      fade_div = 7'd0;
      if (keep_alpha <= {1'b0, ralc_pkg::FULL_SCALE}) begin
        paint(keep_red, keep_green, keep_blue, keep_alpha[7:0]);
        keep_alpha = keep_alpha + 9'd1;
      end else if (anim_mode == ralc_pkg::MODE_FADE_BLINK3) begin
        lit_phase   = 1'b1;
        anim_mode   = ralc_pkg::MODE_BLINK;
        unit_on     = 2'b00;
        keep_alpha  = {1'b0, ralc_pkg::FULL_SCALE};
        blinks_left = ralc_pkg::FADE_BLINKS;
        fades_done++;
      end else begin
        anim_mode = ralc_pkg::MODE_SOLID;
        unit_on   = 2'b00;
        fades_done++;
      end
    end
  endfunction

  function automatic void disco_event(input int unit);
    if (sweep_div[unit] == ralc_pkg::SWEEP_DIVIDE) begin
      sweep_div[unit] = 8'd0;
      if (unit == 0) begin
        sweep_duty(0);
        sweep_duty(1);
      end else begin
        sweep_duty(2);
      end
    end else begin
      sweep_div[unit] = sweep_div[unit] + 8'd1;
    end
  endfunction

  function automatic void blink_event();
    if (anim_mode == ralc_pkg::MODE_BLINK || anim_mode == ralc_pkg::MODE_BLINK_FOREVER) begin
      if (!lit_phase) begin
        paint(keep_red, keep_green, keep_blue, keep_alpha[7:0]);
        lit_phase   = 1'b1;
        blinks_left = blinks_left - 16'd1;
      end else begin
        paint(keep_red, keep_green, keep_blue, 8'd0);
        lit_phase = 1'b0;
        if (blinks_left == 16'd0 && anim_mode == ralc_pkg::MODE_BLINK) begin
          anim_mode = ralc_pkg::MODE_OFF;
          blinks_done++;
        end
      end
    end
  endfunction

  function automatic void enter_mode(input ralc_pkg::ralc_cmd_t w);
    anim_mode = w.mode;
    case (w.mode)
      ralc_pkg::MODE_OFF: begin
        unit_on = 2'b00;
        paint(8'd0, 8'd0, 8'd0, 8'd0);
      end
      ralc_pkg::MODE_SOLID: begin
        unit_on = 2'b00;
        paint(w.red, w.green, w.blue, w.alpha);
      end
      ralc_pkg::MODE_FADE, ralc_pkg::MODE_FADE_BLINK3: begin
        keep_red   = w.red;
        keep_green = w.green;
        keep_blue  = w.blue;
        keep_alpha = 9'd1;
        fading     = 1'b1;
        unit_on    = 2'b01;
      end
      ralc_pkg::MODE_BLINK, ralc_pkg::MODE_BLINK_FOREVER: begin
        unit_on     = 2'b00;
        keep_red    = w.red;
        keep_green  = w.green;
        keep_blue   = w.blue;
        keep_alpha  = {1'b0, w.alpha};
        blinks_left = w.duration;
      end
      ralc_pkg::MODE_DISCO: begin
        fading  = 1'b0;
        unit_on = 2'b11;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic ralc_pkg::ralc_result_t animate(input ralc_pkg::ralc_cmd_t w);
    ralc_pkg::ralc_result_t r;
    int unit;
    case (w.action)
      ralc_pkg::ACT_SET: enter_mode(w);
      ralc_pkg::ACT_TICK: blink_event();
      default: begin
        unit = (w.action == ralc_pkg::ACT_EVT_B) ? 1 : 0;
        if (unit_on[unit]) begin
          if (fading) begin
            fade_event();
          end else begin
            disco_event(unit);
          end
        end
      end
    endcase
    r.red_duty         = duty_val[0];
    r.green_duty       = duty_val[1];
    r.blue_duty        = duty_val[2];
    r.current_mode     = anim_mode;
    r.unit_a_events_on = unit_on[0];
    r.unit_b_events_on = unit_on[1];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch in %s at %0t: expected %0h, got %0h", what, $time, want, got);
    end
  endtask

  function automatic ralc_pkg::ralc_cmd_t word_for(input logic [1:0] act);
    ralc_pkg::ralc_cmd_t w;
    w.action   = act;
    w.mode     = 3'($urandom_range(0, 7));
    w.red      = 8'($urandom_range(0, 255));
    w.green    = 8'($urandom_range(0, 255));
    w.blue     = 8'($urandom_range(0, 255));
    w.alpha    = 8'($urandom_range(0, 255));
    w.duration = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic ralc_pkg::ralc_cmd_t make_word(input logic [2:0] m, input logic [7:0] r,
                                                    input logic [7:0] g, input logic [7:0] b,
                                                    input logic [7:0] a,
                                                    input logic [15:0] dur);
    ralc_pkg::ralc_cmd_t w;
    w.action   = ralc_pkg::ACT_SET;
    w.mode     = m;
    w.red      = r;
    w.green    = g;
    w.blue     = b;
    w.alpha    = a;
    w.duration = dur;
    return w;
  endfunction

  function automatic logic [1:0] follow_action(input logic [2:0] m);
    int r;
    r = $urandom_range(0, 99);
    if (m == ralc_pkg::MODE_BLINK || m == ralc_pkg::MODE_BLINK_FOREVER) begin
      return (r < 80) ? ralc_pkg::ACT_TICK :
             ((r < 90) ? ralc_pkg::ACT_EVT_A : ralc_pkg::ACT_EVT_B);
    end
    if (m == ralc_pkg::MODE_FADE || m == ralc_pkg::MODE_FADE_BLINK3 ||
        m == ralc_pkg::MODE_DISCO) begin
      return (r < 65) ? ralc_pkg::ACT_EVT_A :
             ((r < 90) ? ralc_pkg::ACT_EVT_B : ralc_pkg::ACT_TICK);
    end
    return 2'($urandom_range(1, 3));
  endfunction

  task automatic send_word(input ralc_pkg::ralc_cmd_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.action   <= w.action;
    cmd_ch.mode     <= w.mode;
    cmd_ch.red      <= w.red;
    cmd_ch.green    <= w.green;
    cmd_ch.blue     <= w.blue;
    cmd_ch.alpha    <= w.alpha;
    cmd_ch.duration <= w.duration;
    cmd_ch.valid    <= 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) begin
      @(posedge clk);
    end
    duty_queue.push_back(animate(w));
    words_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (duty_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_check(input logic [1:0] idx, input logic [15:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (prdata[15:0] !== v) begin
      report("register read", {16'd0, v}, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [15:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    case (idx)
      ralc_pkg::REG_PERIOD: period_cfg = v;
      ralc_pkg::REG_SWEEP_MIN: sweep_lo = v;
      ralc_pkg::REG_SWEEP_MAX: sweep_hi = v;
      default: begin
      end
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_check(idx, v);
  endtask

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 4))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return ralc_pkg::PERIOD_RESET;
      3: return 16'($urandom_range(1, 300));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_bound();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 300));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  always @(posedge clk) begin
    ralc_pkg::ralc_result_t want;
    if (!rst && duty_ch.valid && duty_ch.ready) begin
      words_checked++;
      if (duty_queue.size() == 0) begin
        report("unexpected duty word", 32'd0, {16'd0, duty_ch.red_duty});
      end else begin
        want = duty_queue.pop_front();
        if (duty_ch.red_duty !== want.red_duty) begin
          report("red_duty", 32'(want.red_duty), 32'(duty_ch.red_duty));
        end
        if (duty_ch.green_duty !== want.green_duty) begin
          report("green_duty", 32'(want.green_duty), 32'(duty_ch.green_duty));
        end
        if (duty_ch.blue_duty !== want.blue_duty) begin
          report("blue_duty", 32'(want.blue_duty), 32'(duty_ch.blue_duty));
        end
        if (duty_ch.current_mode !== want.current_mode) begin
          report("current_mode", 32'(want.current_mode), 32'(duty_ch.current_mode));
        end
        if (duty_ch.unit_a_events_on !== want.unit_a_events_on) begin
          report("unit_a_events_on", 32'(want.unit_a_events_on),
                 32'(duty_ch.unit_a_events_on));
        end
        if (duty_ch.unit_b_events_on !== want.unit_b_events_on) begin
          report("unit_b_events_on", 32'(want.unit_b_events_on),
                 32'(duty_ch.unit_b_events_on));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      duty_ch.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      duty_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (duty_ch.valid && duty_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d duty words outstanding",
               quiet_cycles, duty_queue.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_reset_values();
    reg_check(ralc_pkg::REG_PERIOD, ralc_pkg::PERIOD_RESET);
    reg_check(ralc_pkg::REG_SWEEP_MIN, ralc_pkg::SWEEP_MIN_RST);
    reg_check(ralc_pkg::REG_SWEEP_MAX, ralc_pkg::SWEEP_MAX_RST);
  endtask

  task automatic test_directed();
    send_word(word_for(ralc_pkg::ACT_EVT_A));
    send_word(word_for(ralc_pkg::ACT_EVT_B));
    send_word(word_for(ralc_pkg::ACT_TICK));
    send_word(make_word(ralc_pkg::MODE_SOLID, 8'hFF, 8'h00, 8'h80, 8'hFF, 16'hFFFF));
    send_word(make_word(ralc_pkg::MODE_SOLID, 8'hFF, 8'hFF, 8'hFF, 8'h00, 16'h0000));
    send_word(make_word(ralc_pkg::MODE_NONE, 8'h12, 8'h34, 8'h56, 8'h78, 16'h5555));
    send_word(make_word(ralc_pkg::MODE_BLINK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd1));
    send_word(word_for(ralc_pkg::ACT_TICK));
    send_word(word_for(ralc_pkg::ACT_TICK));
    send_word(make_word(ralc_pkg::MODE_BLINK, 8'h80, 8'h40, 8'h01, 8'hFE, 16'd0));
    send_word(word_for(ralc_pkg::ACT_TICK));
    send_word(word_for(ralc_pkg::ACT_TICK));
    send_word(make_word(ralc_pkg::MODE_BLINK_FOREVER, 8'h01, 8'hFF, 8'h7F, 8'hAA, 16'hAAAA));
    send_word(word_for(ralc_pkg::ACT_TICK));
    send_word(word_for(ralc_pkg::ACT_TICK));
    send_word(make_word(ralc_pkg::MODE_DISCO, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
    send_word(word_for(ralc_pkg::ACT_EVT_A));
    send_word(word_for(ralc_pkg::ACT_EVT_B));
    send_word(make_word(ralc_pkg::MODE_FADE, 8'hC0, 8'h30, 8'hFF, 8'h55, 16'd7));
    send_word(word_for(ralc_pkg::ACT_EVT_A));
    send_word(word_for(ralc_pkg::ACT_EVT_B));
    send_word(make_word(ralc_pkg::MODE_OFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    settle();
    reg_write(ralc_pkg::REG_PERIOD, 16'd0);
    send_word(make_word(ralc_pkg::MODE_SOLID, 8'h00, 8'h00, 8'h00, 8'hFF, 16'd0));
    send_word(make_word(ralc_pkg::MODE_OFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
    settle();
    reg_write(ralc_pkg::REG_PERIOD, 16'd1);
    send_word(make_word(ralc_pkg::MODE_SOLID, 8'h01, 8'hFF, 8'h02, 8'hFF, 16'd0));
    settle();
    reg_write(ralc_pkg::REG_PERIOD, 16'hFFFF);
    reg_write(ralc_pkg::REG_SWEEP_MIN, 16'hFFFF);
    reg_write(ralc_pkg::REG_SWEEP_MAX, 16'h0000);
    send_word(make_word(ralc_pkg::MODE_SOLID, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0));
    settle();
    reg_write(ralc_pkg::REG_PERIOD, ralc_pkg::PERIOD_RESET);
    reg_write(ralc_pkg::REG_SWEEP_MIN, ralc_pkg::SWEEP_MIN_RST);
    reg_write(ralc_pkg::REG_SWEEP_MAX, ralc_pkg::SWEEP_MAX_RST);
  endtask

  task automatic test_backpressure();
    send_word(make_word(ralc_pkg::MODE_BLINK_FOREVER, 8'h90, 8'h20, 8'hE0, 8'hC8, 16'd5));
    hold_left = 300;
    for (int i = 0; i < 60; i++) begin
      send_word(word_for(follow_action(ralc_pkg::MODE_BLINK_FOREVER)));
    end
    settle();
  endtask

  task automatic test_random(input int count);
    int stop;
    int burst;
    ralc_pkg::ralc_cmd_t w;
    settle();
    reg_write(ralc_pkg::REG_PERIOD, pick_period());
    reg_write(ralc_pkg::REG_SWEEP_MIN, pick_bound());
    reg_write(ralc_pkg::REG_SWEEP_MAX, pick_bound());
    stop = words_sent + count;
    while (words_sent < stop) begin
      if ($urandom_range(0, 99) < 15) begin
        send_word(word_for(2'($urandom_range(0, 3))));
      end else begin
        w = word_for(ralc_pkg::ACT_SET);
        if ((w.mode == ralc_pkg::MODE_BLINK || w.mode == ralc_pkg::MODE_BLINK_FOREVER) &&
            $urandom_range(0, 3) != 0) begin
          w.duration = 16'($urandom_range(0, 4));
        end
        send_word(w);
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst; k++) begin
          send_word(word_for(follow_action(w.mode)));
        end
      end
    end
    settle();
  endtask

  task automatic test_disco(input logic [15:0] lo, input logic [15:0] hi, input int steps);
    settle();
    reg_write(ralc_pkg::REG_SWEEP_MIN, lo);
    reg_write(ralc_pkg::REG_SWEEP_MAX, hi);
    send_word(make_word(ralc_pkg::MODE_SOLID, 8'($urandom_range(0, 12)),
                        8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                        8'hFF, 16'd0));
    send_word(make_word(ralc_pkg::MODE_DISCO, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
    for (int i = 0; i < steps * 256; i++) begin
      send_word(word_for(($urandom_range(0, 1) != 0) ? ralc_pkg::ACT_EVT_A :
                                                       ralc_pkg::ACT_EVT_B));
    end
    send_word(make_word(ralc_pkg::MODE_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
    for (int i = 0; i < 16; i++) begin
      send_word(word_for(ralc_pkg::ACT_EVT_A));
    end
    settle();
  endtask

  task automatic finish_run();
    settle();
    repeat (8) @(posedge clk);
    $display("Run covered %0d command words and %0d checked duty words, %0d fade endings,",
             words_sent, words_checked, fades_done);
    $display("%0d completed blink sequences, stalls, random limits and a narrow disco sweep.",
             blinks_done);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = 32'd0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.action    = ralc_pkg::ACT_TICK;
    cmd_ch.mode      = ralc_pkg::MODE_OFF;
    cmd_ch.red       = 8'd0;
    cmd_ch.green     = 8'd0;
    cmd_ch.blue      = 8'd0;
    cmd_ch.alpha     = 8'd0;
    cmd_ch.duration  = 16'd0;
    duty_ch.ready    = 1'b0;
    src_idle         = 13;
    snk_idle         = 87;
    hold_left        = 0;
    model_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed();
    test_backpressure();
    test_random(100);
    src_idle = 87;
    snk_idle = 13;
    test_random(100);
    src_idle = 0;
    snk_idle = 0;
    test_random(100);
    test_disco(16'd3, 16'd8, 2);
    finish_run();
  end

endmodule
